// File: rtl/ptd_pkg.sv
package ptd_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int PROD_W     = 34;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POINT_COUNT   = 3'd0,
        CFG_POINT_ZERO    = 3'd1,
        CFG_POINT_ONE     = 3'd2,
        CFG_POINT_TWO     = 3'd3,
        CFG_POINT_THREE   = 3'd4,
        CFG_DISCARD_COUNT = 3'd5,
        CFG_PASSES_NEEDED = 3'd6,
        CFG_SAMPLE_BUDGET = 3'd7
    } t_cfg_idx;

    localparam logic [2:0]  POINT_COUNT_RST   = 3'd4;
    localparam logic [7:0]  DISCARD_COUNT_RST = 8'd1;
    localparam logic [7:0]  PASSES_NEEDED_RST = 8'd3;
    localparam logic [7:0]  SAMPLE_BUDGET_RST = 8'd10;
    // x in upper half, threshold in lower half
    localparam logic [31:0] POINT_RST [4] = '{32'd58, 32'd1966138, 32'd4915312, 32'd13107437};

    typedef struct packed {
        logic [2:0] point_count;
        logic [7:0] discard_count;
        logic [7:0] passes_needed;
        logic [7:0] sample_budget;
    } t_cfg;

    typedef struct packed {
        logic [15:0] off_mv;
        logic [15:0] on_mv;
        logic        start_req;
    } t_in_word;

    typedef struct packed {
        logic       was_discarded;
        logic       above_threshold;
        logic [7:0] pass_count;
        logic       finished;
        logic       detected;
    } t_out_word;

endpackage

// File: rtl/ptd_in_if.sv
interface ptd_in_if import ptd_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/ptd_out_if.sv
interface ptd_out_if import ptd_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/ptd_cfg.sv
module ptd_cfg import ptd_pkg::*; #(
    parameter int MAX_POINTS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg,
    output logic [31:0]           o_points [MAX_POINTS]
);

    t_cfg        r_cfg;
    logic [31:0] r_points [MAX_POINTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.point_count   <= POINT_COUNT_RST;
            r_cfg.discard_count <= DISCARD_COUNT_RST;
            r_cfg.passes_needed <= PASSES_NEEDED_RST;
            r_cfg.sample_budget <= SAMPLE_BUDGET_RST;
            for (int k = 0; k < MAX_POINTS; k++) begin
                r_points[k] <= POINT_RST[k];
            end
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_POINT_COUNT:   r_cfg.point_count   <= i_cfg_data[2:0];
                CFG_DISCARD_COUNT: r_cfg.discard_count <= i_cfg_data[7:0];
                CFG_PASSES_NEEDED: r_cfg.passes_needed <= i_cfg_data[7:0];
                CFG_SAMPLE_BUDGET: r_cfg.sample_budget <= i_cfg_data[7:0];
                default: ;
            endcase
            // breakpoint registers beyond the table depth are dropped
            for (int k = 0; k < MAX_POINTS; k++) begin
                if (i_cfg_idx == CFG_IDX_W'(int'(CFG_POINT_ZERO) + k)) begin
                    r_points[k] <= i_cfg_data;
                end
            end
        end
    end

    assign o_cfg    = r_cfg;
    assign o_points = r_points;

endmodule

// File: rtl/ptd_thresh.sv
module ptd_thresh import ptd_pkg::*; #(
    parameter int MAX_POINTS = 4
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [2:0]               i_point_count,
    input  logic [31:0]              i_points [MAX_POINTS],
    input  logic [15:0]              i_off_mv,
    input  logic [15:0]              i_on_mv,
    output logic signed [PROD_W-1:0] o_lhs,
    output logic signed [PROD_W-1:0] o_rhs
);

    localparam int SEG_W = $clog2(MAX_POINTS);

    logic [2:0]              n_eff;
    logic [SEG_W-1:0]        seg;
    logic [15:0]             x0, y0, x1, y1;
    logic signed [16:0]      dx, dy, abs_dx, sdy, d_on, d_off;
    logic signed [PROD_W-1:0] n_lhs, n_rhs;
    logic signed [PROD_W-1:0] r_lhs, r_rhs;

    always_comb begin
        if (i_point_count < 3'd2) begin
            n_eff = 3'd2;
        end else if (i_point_count > 3'(MAX_POINTS)) begin
            n_eff = 3'(MAX_POINTS);
        end else begin
            n_eff = i_point_count;
        end

        // fallback is the last segment; lowest matching segment wins
        seg = SEG_W'(n_eff - 3'd2);
        for (int k = MAX_POINTS - 3; k >= 0; k--) begin
            if (3'(k + 2) < n_eff && i_off_mv >= i_points[k][31:16]
                    && i_off_mv <= i_points[k+1][31:16]) begin
                seg = SEG_W'(k);
            end
        end

        x0 = '0;
        y0 = '0;
        x1 = '0;
        y1 = '0;
        for (int k = 0; k < MAX_POINTS - 1; k++) begin
            if (seg == SEG_W'(k)) begin
                x0 = i_points[k][31:16];
                y0 = i_points[k][15:0];
                x1 = i_points[k+1][31:16];
                y1 = i_points[k+1][15:0];
            end
        end

        dx    = $signed({1'b0, x1}) - $signed({1'b0, x0});
        dy    = $signed({1'b0, y1}) - $signed({1'b0, y0});
        d_on  = $signed({1'b0, i_on_mv}) - $signed({1'b0, y0});
        d_off = $signed({1'b0, i_off_mv}) - $signed({1'b0, x0});

        // zero-width segment (x1 == x0): reduces to on >= y0
        if (dx == 17'sd0) begin
            abs_dx = 17'sd1;
            sdy    = 17'sd0;
        end else if (dx[16]) begin
            abs_dx = -dx;
            sdy    = -dy;
        end else begin
            abs_dx = dx;
            sdy    = dy;
        end

        n_lhs = PROD_W'(d_on) * PROD_W'(abs_dx);
        n_rhs = PROD_W'(sdy) * PROD_W'(d_off);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lhs <= n_lhs;
            r_rhs <= n_rhs;
        end
    end

    assign o_lhs = r_lhs;
    assign o_rhs = r_rhs;

endmodule

// File: rtl/ptd_track.sv
module ptd_track import ptd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cfg                     i_cfg,
    input  logic                     i_valid,
    input  logic                     i_start,
    input  logic signed [PROD_W-1:0] i_lhs,
    input  logic signed [PROD_W-1:0] i_rhs,
    output logic                     o_adv,
    ptd_out_if.source                o_res
);

    logic [8:0]         r_idx, n_idx, cur_idx, idx_nx;
    logic [7:0]         r_passes, n_passes, cur_p, p_nx;
    logic               r_done, n_done, cur_done;
    logic               r_out_v;
    t_out_word          r_out, res;
    logic               has_res, pass, fin, det;
    logic signed [10:0] limit0, lim;

    always_comb begin
        pass     = i_lhs >= i_rhs;
        limit0   = $signed({3'b0, i_cfg.sample_budget}) - $signed({3'b0, i_cfg.passes_needed})
                   + 11'sd1;
        cur_idx  = i_start ? 9'd0 : r_idx;
        cur_p    = i_start ? 8'd0 : r_passes;
        cur_done = i_start ? 1'b0 : r_done;

        n_idx    = r_idx;
        n_passes = r_passes;
        n_done   = r_done;
        res      = '0;
        has_res  = 1'b0;
        fin      = 1'b0;
        det      = 1'b0;
        p_nx     = cur_p;
        idx_nx   = cur_idx + 9'd1;
        lim      = limit0;

        if (i_start && limit0 <= 11'sd0) begin
            // empty budget: report finished without evaluating
            n_idx        = '0;
            n_passes     = '0;
            n_done       = 1'b1;
            has_res      = 1'b1;
            res.finished = 1'b1;
        end else if (!cur_done) begin
            has_res = 1'b1;
            if (cur_idx < {1'b0, i_cfg.discard_count}) begin
                res.was_discarded = 1'b1;
            end else if (pass) begin
                res.above_threshold = 1'b1;
                p_nx = cur_p + 8'd1;
                if (p_nx >= i_cfg.passes_needed) begin
                    fin = 1'b1;
                    det = 1'b1;
                end
            end else begin
                p_nx = '0;
            end
            lim = limit0 + $signed({3'b0, p_nx});
            if (!fin && $signed({2'b0, idx_nx}) >= lim) begin
                fin = 1'b1;
            end
            n_idx          = idx_nx;
            n_passes       = p_nx;
            n_done         = fin;
            res.pass_count = p_nx;
            res.finished   = fin;
            res.detected   = det;
        end
    end

    assign o_adv = i_valid && (!r_out_v || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_passes <= '0;
            r_done   <= 1'b1;
            r_out_v  <= 1'b0;
        end else begin
            if (o_adv) begin
                r_idx    <= n_idx;
                r_passes <= n_passes;
                r_done   <= n_done;
            end
            if (o_adv && has_res) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && has_res) begin
            r_out <= res;
        end
    end

    assign o_res.valid = r_out_v;
    assign o_res.data  = r_out;

    a_fin_sets_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_adv && has_res && res.finished) |=> r_done)
        else $error("finished word did not close the measurement");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_adv && !i_start && r_done) |=> ($stable(r_idx) && $stable(r_passes)))
        else $error("counters moved while idle");

    a_disc_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_adv && has_res && res.was_discarded) |-> (!res.above_threshold && !res.detected))
        else $error("discarded sample flagged as pass");

    a_det_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_adv && has_res && res.detected)
            |-> (res.finished && res.pass_count >= i_cfg.passes_needed))
        else $error("detection without enough passes");

endmodule

// File: rtl/piecewise_threshold_detector.sv
// Registers from input accept to result valid: input register, product register,
// result register.
// Throughput: one word per cycle unless o_res.ready stalls the output; the pass
// counter and sample index update per word; the 17x17 products have their own pipeline stage.
// Reset (synchronous, active low): pipeline empty, counters cleared, idle until a
// start request; configuration returns to the default four-point table.
module piecewise_threshold_detector import ptd_pkg::*; #(
    parameter int MAX_POINTS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ptd_in_if.sink                i_in,
    ptd_out_if.source             o_res
);

    t_cfg                     cfg;
    logic [31:0]              points [MAX_POINTS];
    logic                     r_s1_v, r_s2_v, r_s2_start;
    t_in_word                 r_s1;
    logic                     s1_adv, s2_adv;
    logic signed [PROD_W-1:0] lhs, rhs;

    ptd_cfg #(.MAX_POINTS(MAX_POINTS)) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg),
        .o_points   (points)
    );

    assign s1_adv     = r_s1_v && (!r_s2_v || s2_adv);
    assign i_in.ready = !r_s1_v || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_s1_v <= i_in.valid;
            end
            if (s1_adv) begin
                r_s2_v <= 1'b1;
            end else if (s2_adv) begin
                r_s2_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1 <= i_in.data;
        end
        if (s1_adv) begin
            r_s2_start <= r_s1.start_req;
        end
    end

    ptd_thresh #(.MAX_POINTS(MAX_POINTS)) u_thresh (
        .i_clk         (i_clk),
        .i_en          (s1_adv),
        .i_point_count (cfg.point_count),
        .i_points      (points),
        .i_off_mv      (r_s1.off_mv),
        .i_on_mv       (r_s1.on_mv),
        .o_lhs         (lhs),
        .o_rhs         (rhs)
    );

    ptd_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (r_s2_v),
        .i_start (r_s2_start),
        .i_lhs   (lhs),
        .i_rhs   (rhs),
        .o_adv   (s2_adv),
        .o_res   (o_res)
    );

endmodule
